>>> rtl/core/i2c_eeprom_page_master_top_defines.svh
// Assertion macros for the I2C EEPROM page master engine.
`ifndef I2C_EEPROM_PAGE_MASTER_TOP_DEFINES_SVH
`define I2C_EEPROM_PAGE_MASTER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Antecedent and consequent in the same cycle.
`define I2CEP_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed in same-cycle check");
// Consequent in the cycle after the antecedent.
`define I2CEP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed in next-cycle check");
`else
`define I2CEP_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define I2CEP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> rtl/core/i2cep_pkg.sv
// Types and constants of the I2C EEPROM page master.
package i2cep_pkg;

    localparam int PAGE_BYTES = 8;
    localparam int BUF_DEPTH  = 8;
    localparam int BUF_IDX_W  = 3;
    localparam int CNT_W      = 4;

    localparam logic [CNT_W-1:0] LAST_BYTE = CNT_W'(PAGE_BYTES - 1);
    localparam logic [CNT_W-1:0] BITS_PER_BYTE = CNT_W'(8);

    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;

    // Configuration register indexes.
    localparam logic CFG_DEVICE_ADDRESS = 1'b0;
    localparam logic CFG_WORD_ADDRESS   = 1'b1;

    localparam logic RW_WRITE = 1'b0;
    localparam logic RW_READ  = 1'b1;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_LOAD  = 2'd1,
        FUNC_WRITE = 2'd2,
        FUNC_READ  = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_ST0  = 4'd1,
        PH_ST1  = 4'd2,
        PH_ST2  = 4'd3,
        PH_TXD  = 4'd4,
        PH_TXH  = 4'd5,
        PH_TAD  = 4'd6,
        PH_TAH  = 4'd7,
        PH_RXD  = 4'd8,
        PH_RXH  = 4'd9,
        PH_MAD  = 4'd10,
        PH_MAH  = 4'd11,
        PH_SP0  = 4'd12,
        PH_SP1  = 4'd13
    } phase_t;

    typedef enum logic [2:0] {
        SEG_ADDRW = 3'd0,
        SEG_WORD  = 3'd1,
        SEG_DATA  = 3'd2,
        SEG_ADDRR = 3'd3,
        SEG_RX    = 3'd4
    } seg_t;

    typedef struct packed {
        func_t                func;
        logic [BUF_IDX_W-1:0] byte_index;
        logic [7:0]           byte_value;
        logic                 sda_in;
    } beat_t;

    typedef struct packed {
        logic                 scl_level;
        logic                 sda_level;
        logic                 busy_res;
        logic                 done_res;
        logic                 read_valid;
        logic [BUF_IDX_W-1:0] read_index;
        logic [7:0]           read_byte;
        logic                 ack_missing;
    } result_t;

endpackage

>>> rtl/core/i2c_eeprom_page_master_top.sv
// Top level of the I2C EEPROM page master.
//
// Every beat on the slave stream is one half-bit tick of the I2C bus. s_tuser
// carries the command (tick only, load a write-buffer byte, start a page write
// or start a page read); s_tdata carries the buffer index, the byte to load and
// the sampled SDA level. Each accepted beat gives exactly one beat on the master
// stream with the SCL and SDA levels for that phase, busy, done, a received
// byte when one completes, and the sticky missing-ACK flag.
// The cfg channel writes the device address (index 0) and the word address
// (index 1); it is always ready and should be used only while the block is idle.
// A beat passes an input register, one pass of the phase logic and a result
// register; m_tvalid rises once the result register takes the beat, which waits
// while an older result is still held. One beat is taken per clock as long as
// the receiver keeps up; the phase state updates once per beat.
// When m_tready stays low, the result register holds and one more beat can
// wait in the input register before s_tready drops.
// Reset (rst_n low, asynchronous) returns the sequencer to idle with both bus
// lines released, device address 80 and word address 0. The write buffer is
// not cleared and must be loaded before a page write.
module i2c_eeprom_page_master_top
    import i2cep_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // byte_index[2:0], byte_value[10:3], sda_in[11]
    input  logic [IN_USER_W-1:0]  s_tuser,   // func[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // scl_level[0], sda_level[1], busy_res[2], done_res[3], read_valid[4],
    // read_index[7:5], read_byte[15:8], ack_missing[16]
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [7:0]            cfg_data
);

    logic    step;
    logic    space;
    beat_t   beat;
    result_t res;
    result_t res_out;

    assign cfg_ready = 1'b1;

    i2cep_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .space    (space),
        .step     (step),
        .beat     (beat)
    );

    i2cep_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step),
        .beat      (beat),
        .res       (res)
    );

    i2cep_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .res      (res),
        .space    (space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .res_out  (res_out)
    );

    assign m_tdata = {7'd0, res_out.ack_missing, res_out.read_byte, res_out.read_index,
                      res_out.read_valid, res_out.done_res, res_out.busy_res,
                      res_out.sda_level, res_out.scl_level};

endmodule

>>> rtl/core/i2cep_in_stage.sv
// Input register of the I2C EEPROM page master: holds one accepted tick beat.
module i2cep_in_stage
    import i2cep_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic [IN_USER_W-1:0] s_tuser,
    input  logic                 space,
    output logic                 step,
    output beat_t                beat
);

    logic  valid_reg;
    logic  valid_next;
    beat_t beat_reg;

    assign step     = valid_reg && space;
    assign s_tready = !valid_reg || step;
    assign beat     = beat_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
        else if (step)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            beat_reg.func       <= func_t'(s_tuser[1:0]);
            beat_reg.byte_index <= s_tdata[2:0];
            beat_reg.byte_value <= s_tdata[10:3];
            beat_reg.sda_in     <= s_tdata[11];
        end
    end

endmodule

>>> rtl/core/i2cep_engine.sv
// Bus phase sequencer, write buffer and address registers of the page master.
`include "i2c_eeprom_page_master_top_defines.svh"
module i2cep_engine
    import i2cep_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       step,
    input  beat_t      beat,
    output result_t    res
);

    phase_t           phase_reg, phase_next;
    seg_t             seg_reg, seg_next;
    logic [CNT_W-1:0] bit_reg, bit_next;
    logic [CNT_W-1:0] byte_reg, byte_next;
    logic [7:0]       shift_reg, shift_next;
    logic             is_read_reg, is_read_next;
    logic             ack_reg, ack_next;
    logic [6:0]       dev_addr_reg;
    logic [7:0]       word_addr_reg;
    logic [7:0]       wbuf_reg [BUF_DEPTH];

    logic             buf_we;
    logic             load_tx;
    logic [7:0]       tx_byte;
    logic [CNT_W-1:0] bit_inc;
    logic             last_cur;
    logic             last_nxt;
    logic             rx_valid;
    logic             stop_done;
    logic             scl_out;
    logic             sda_out;

    assign bit_inc  = bit_reg + CNT_W'(1);
    assign last_cur = byte_reg >= LAST_BYTE;
    assign last_nxt = byte_next >= LAST_BYTE;

    always_comb
    begin
        phase_next   = phase_reg;
        seg_next     = seg_reg;
        bit_next     = bit_reg;
        byte_next    = byte_reg;
        shift_next   = shift_reg;
        is_read_next = is_read_reg;
        ack_next     = ack_reg;
        buf_we       = 1'b0;
        load_tx      = 1'b0;
        rx_valid     = 1'b0;
        stop_done    = 1'b0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (beat.func == FUNC_LOAD)
                begin
                    buf_we = 1'b1;
                end
                else if (beat.func == FUNC_WRITE || beat.func == FUNC_READ)
                begin
                    is_read_next = (beat.func == FUNC_READ);
                    seg_next     = SEG_ADDRW;
                    byte_next    = '0;
                    bit_next     = '0;
                    shift_next   = '0;
                    ack_next     = 1'b0;
                    phase_next   = PH_ST0;
                end
            end
            PH_ST0: phase_next = PH_ST1;
            PH_ST1: phase_next = PH_ST2;
            PH_ST2: load_tx = 1'b1;
            PH_TXD: phase_next = PH_TXH;
            PH_TXH:
            begin
                shift_next = {shift_reg[6:0], 1'b0};
                bit_next   = bit_inc;
                phase_next = (bit_inc >= BITS_PER_BYTE) ? PH_TAD : PH_TXD;
            end
            PH_TAD:
            begin
                phase_next = PH_TAH;
                if (beat.sda_in)
                begin
                    ack_next = 1'b1;
                end
            end
            PH_TAH:
            begin
                unique case (seg_reg)
                    SEG_ADDRW:
                    begin
                        seg_next = SEG_WORD;
                        load_tx  = 1'b1;
                    end
                    SEG_WORD:
                    begin
                        if (is_read_reg)
                        begin
                            seg_next   = SEG_ADDRR;
                            phase_next = PH_ST0;
                        end
                        else
                        begin
                            seg_next  = SEG_DATA;
                            byte_next = '0;
                            load_tx   = 1'b1;
                        end
                    end
                    SEG_DATA:
                    begin
                        if (last_cur)
                        begin
                            phase_next = PH_SP0;
                        end
                        else
                        begin
                            byte_next = byte_reg + CNT_W'(1);
                            load_tx   = 1'b1;
                        end
                    end
                    default:
                    begin
                        seg_next   = SEG_RX;
                        byte_next  = '0;
                        bit_next   = '0;
                        shift_next = '0;
                        phase_next = PH_RXD;
                    end
                endcase
            end
            PH_RXD:
            begin
                phase_next = PH_RXH;
                shift_next = {shift_reg[6:0], beat.sda_in};
                bit_next   = bit_inc;
                rx_valid   = (bit_inc >= BITS_PER_BYTE);
            end
            PH_RXH: phase_next = (bit_reg >= BITS_PER_BYTE) ? PH_MAD : PH_RXD;
            PH_MAD: phase_next = PH_MAH;
            PH_MAH:
            begin
                if (last_cur)
                begin
                    phase_next = PH_SP0;
                end
                else
                begin
                    byte_next  = byte_reg + CNT_W'(1);
                    bit_next   = '0;
                    shift_next = '0;
                    phase_next = PH_RXD;
                end
            end
            PH_SP0: phase_next = PH_SP1;
            PH_SP1:
            begin
                phase_next = PH_IDLE;
                stop_done  = 1'b1;
            end
            default: phase_next = PH_IDLE;
        endcase

        // A byte transmit starts with the segment and byte position just chosen.
        unique case (seg_next)
            SEG_ADDRW: tx_byte = {dev_addr_reg, RW_WRITE};
            SEG_WORD:  tx_byte = word_addr_reg;
            SEG_DATA:  tx_byte = wbuf_reg[byte_next[BUF_IDX_W-1:0]];
            default:   tx_byte = {dev_addr_reg, RW_READ};
        endcase
        if (load_tx)
        begin
            shift_next = tx_byte;
            bit_next   = '0;
            phase_next = PH_TXD;
        end

        unique case (phase_next)
            PH_ST0:          begin scl_out = 1'b0; sda_out = 1'b1;          end
            PH_ST2:          begin scl_out = 1'b1; sda_out = 1'b0;          end
            PH_TXD:          begin scl_out = 1'b0; sda_out = shift_next[7]; end
            PH_TXH:          begin scl_out = 1'b1; sda_out = shift_next[7]; end
            PH_TAD, PH_RXD:  begin scl_out = 1'b0; sda_out = 1'b1;          end
            PH_MAD:          begin scl_out = 1'b0; sda_out = last_nxt;      end
            PH_MAH:          begin scl_out = 1'b1; sda_out = last_nxt;      end
            PH_SP0:          begin scl_out = 1'b0; sda_out = 1'b0;          end
            PH_SP1:          begin scl_out = 1'b1; sda_out = 1'b0;          end
            default:         begin scl_out = 1'b1; sda_out = 1'b1;          end
        endcase

        res.scl_level   = scl_out;
        res.sda_level   = sda_out;
        res.busy_res    = (phase_next != PH_IDLE);
        res.done_res    = stop_done;
        res.read_valid  = rx_valid;
        res.read_index  = rx_valid ? byte_next[BUF_IDX_W-1:0] : '0;
        res.read_byte   = rx_valid ? shift_next : 8'd0;
        res.ack_missing = ack_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            seg_reg     <= SEG_ADDRW;
            bit_reg     <= '0;
            byte_reg    <= '0;
            shift_reg   <= '0;
            is_read_reg <= 1'b0;
            ack_reg     <= 1'b0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            seg_reg     <= seg_next;
            bit_reg     <= bit_next;
            byte_reg    <= byte_next;
            shift_reg   <= shift_next;
            is_read_reg <= is_read_next;
            ack_reg     <= ack_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg  <= 7'd80;
            word_addr_reg <= 8'd0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_DEVICE_ADDRESS)
            begin
                dev_addr_reg <= cfg_data[6:0];
            end
            else
            begin
                word_addr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && buf_we)
        begin
            wbuf_reg[beat.byte_index] <= beat.byte_value;
        end
    end

    `I2CEP_ASSERT_NEXT(a_done_to_idle, clk, rst_n, step && res.done_res, phase_reg == PH_IDLE)
    `I2CEP_ASSERT_SAME(a_rx_only_in_rxd, clk, rst_n, res.read_valid, phase_reg == PH_RXD)
    `I2CEP_ASSERT_SAME(a_bit_count_range, clk, rst_n, 1'b1, bit_reg <= BITS_PER_BYTE)
    `I2CEP_ASSERT_NEXT(a_busy_tracks_phase, clk, rst_n, step,
                       (phase_reg != PH_IDLE) == $past(res.busy_res))

endmodule

>>> rtl/core/i2cep_out_stage.sv
// Result register of the I2C EEPROM page master: holds one beat for the receiver.
module i2cep_out_stage
    import i2cep_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  result_t res,
    output logic    space,
    output logic    m_tvalid,
    input  logic    m_tready,
    output result_t res_out
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign space    = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign res_out  = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (step)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res;
        end
    end

endmodule
